>>> src/ntda_pkg.sv
// shared types, constants and microcode table for number_to_decimal_ascii
// no dependencies; used by ntda_useq and number_to_decimal_ascii
package ntda_pkg;

    localparam int VALUE_W            = 48;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int MAX_INT_DIGITS_DEF = 10;
    localparam int PC_W               = 4;

    // command codes
    localparam logic [1:0] CMD_UNSIGNED = 2'd0;
    localparam logic [1:0] CMD_SIGNED   = 2'd1;
    localparam logic [1:0] CMD_FIXED    = 2'd2;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_POINT = 8'd46;

    // divide by ten: q = (n * RECIP10) >> RECIP_SHIFT, exact for 32-bit n
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SIGN,
        OP_MUL,
        OP_DIV,
        OP_POP,
        OP_POINT,
        OP_FRAC,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NOT_NEG,
        C_Q_NZ,
        C_SP_MORE,
        C_NOT_FIX,
        C_DEC_ZERO,
        C_DEC_MORE
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic neg;
        logic fix;
        logic q_nz;
        logic sp_more;
        logic dec_zero;
        logic dec_more;
        logic out_busy;
    } status_t;

    // program steps
    localparam logic [PC_W-1:0] PC_SIGN = 4'd1;
    localparam logic [PC_W-1:0] PC_MUL  = 4'd2;
    localparam logic [PC_W-1:0] PC_POP  = 4'd4;
    localparam logic [PC_W-1:0] PC_FRAC = 4'd7;
    localparam logic [PC_W-1:0] PC_DONE = 4'd8;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_DONE, cond: C_NEVER, target: PC_DONE};
        case (pc)
            4'd0: w = '{op: OP_NOP,   cond: C_NOT_NEG,  target: PC_MUL};
            4'd1: w = '{op: OP_SIGN,  cond: C_NEVER,    target: PC_SIGN};
            4'd2: w = '{op: OP_MUL,   cond: C_NEVER,    target: PC_MUL};
            4'd3: w = '{op: OP_DIV,   cond: C_Q_NZ,     target: PC_MUL};
            4'd4: w = '{op: OP_POP,   cond: C_SP_MORE,  target: PC_POP};
            4'd5: w = '{op: OP_NOP,   cond: C_NOT_FIX,  target: PC_DONE};
            4'd6: w = '{op: OP_POINT, cond: C_DEC_ZERO, target: PC_DONE};
            4'd7: w = '{op: OP_FRAC,  cond: C_DEC_MORE, target: PC_FRAC};
            default: w = '{op: OP_DONE, cond: C_NEVER, target: PC_DONE};
        endcase
        return w;
    endfunction

endpackage

>>> src/number_to_decimal_ascii.sv
// number_to_decimal_ascii: one number per request in, its decimal ascii characters out,
// most significant first, with the final character flagged on m_last.
// Each request is taken while the block is idle, then a microcoded sequencer walks a small
// program: optional '-', integer digits by repeated divide-by-ten (a 32x32 reciprocal multiply
// followed by a step that takes the quotient and remainder, digits pushed on a digit stack), one
// popped digit per cycle, then in fixed-point mode '.' and one fractional digit per cycle
// (fraction times ten), each emitting step held while the one-character output register is
// still occupied; after the last character is loaded the sequencer runs its DONE step (in the
// integer modes a NOP step before it) and returns to idle, where it takes the next request.
// Mode 0 prints the low 32 bits unsigned, mode 1 signed, mode 2 is signed fixed point with
// FRAC_BITS fractional bits and an integer part saturated at 32 bits; mode 3 acts as mode 0.
// Depends on ntda_pkg and ntda_useq.
module number_to_decimal_ascii #(
    parameter int FRAC_BITS      = ntda_pkg::FRAC_BITS_DEF,
    parameter int MAX_INT_DIGITS = ntda_pkg::MAX_INT_DIGITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request side
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_command,
    input  logic signed [ntda_pkg::VALUE_W-1:0] s_value,
    input  logic [3:0]                         s_decimals,
    // character side
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_character,
    output logic                               m_last
);

    localparam int VW    = ntda_pkg::VALUE_W;
    localparam int CNT_W = $clog2(MAX_INT_DIGITS + 1);
    localparam int IDX_W = (MAX_INT_DIGITS > 1) ? $clog2(MAX_INT_DIGITS) : 1;

    // sequencer link
    logic               accept;
    logic               idle;
    logic               step_en;
    ntda_pkg::op_t      op;
    ntda_pkg::status_t  status;

    // working registers
    logic                  neg_reg;
    logic                  fix_reg;
    logic [31:0]           num_reg;
    logic [63:0]           prod_reg;
    logic [FRAC_BITS-1:0]  frac_reg;
    logic [3:0]            dec_reg;
    logic [CNT_W-1:0]      sp_reg;
    logic [3:0]            dig_mem [MAX_INT_DIGITS];

    // output register
    logic        m_valid_reg;
    logic [7:0]  m_character_reg;
    logic        m_last_reg;

    // request decode
    logic              is_fix;
    logic              is_signed;
    logic [VW-1:0]     vbits;
    logic [VW-1:0]     mag48;
    logic [VW-1:0]     ipart48;
    logic [31:0]       w32;
    logic [31:0]       num_load;
    logic              neg_load;

    // digit arithmetic
    logic [31:0]           quot;
    logic [31:0]           quot10;
    logic [31:0]           rem32;
    logic [FRAC_BITS+3:0]  frac_ext;
    logic [FRAC_BITS+3:0]  frac10;
    logic [3:0]            top_digit;

    assign accept = s_valid && s_ready;
    assign s_ready = idle;

    always_comb begin
        is_fix    = (s_command == ntda_pkg::CMD_FIXED);
        is_signed = (s_command == ntda_pkg::CMD_SIGNED);
        vbits     = $unsigned(s_value);
        // two's complement magnitude, 48 bits in fixed point and 32 bits in signed mode
        mag48     = (is_fix && vbits[VW-1]) ? (~vbits + {{(VW-1){1'b0}}, 1'b1}) : vbits;
        ipart48   = mag48 >> FRAC_BITS;
        w32       = (is_signed && vbits[31]) ? (~vbits[31:0] + 32'd1) : vbits[31:0];
        if (is_fix) begin
            // saturate an integer part that does not fit in 32 bits
            num_load = (|ipart48[VW-1:32]) ? 32'hFFFF_FFFF : ipart48[31:0];
        end else begin
            num_load = w32;
        end
        neg_load  = (is_fix && vbits[VW-1]) || (is_signed && vbits[31]);
    end

    // quotient from the reciprocal product, remainder by subtraction
    assign quot      = 32'(prod_reg[63:ntda_pkg::RECIP_SHIFT]);
    assign quot10    = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
    assign rem32     = num_reg - quot10;

    // fraction times ten: the bits above the binary point are the next digit
    assign frac_ext  = {4'b0000, frac_reg};
    assign frac10    = (frac_ext << 3) + (frac_ext << 1);
    assign top_digit = frac10[FRAC_BITS+3:FRAC_BITS];

    always_comb begin
        status.neg      = neg_reg;
        status.fix      = fix_reg;
        status.q_nz     = |quot;
        status.sp_more  = (sp_reg > CNT_W'(1));
        status.dec_zero = (dec_reg == 4'd0);
        status.dec_more = (dec_reg > 4'd1);
        status.out_busy = m_valid_reg && !m_ready;
    end

    ntda_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .status  (status),
        .idle    (idle),
        .step_en (step_en),
        .op      (op)
    );

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            neg_reg  <= neg_load;
            fix_reg  <= is_fix;
            num_reg  <= num_load;
            frac_reg <= mag48[FRAC_BITS-1:0];
            dec_reg  <= s_decimals;
        end else if (step_en) begin
            case (op)
                ntda_pkg::OP_MUL: begin
                    prod_reg <= num_reg * ntda_pkg::RECIP10;
                end
                ntda_pkg::OP_DIV: begin
                    dig_mem[IDX_W'(sp_reg)] <= rem32[3:0];
                    num_reg                 <= quot;
                end
                ntda_pkg::OP_FRAC: begin
                    frac_reg <= frac10[FRAC_BITS-1:0];
                    dec_reg  <= dec_reg - 4'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // digit stack pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (accept) begin
            sp_reg <= '0;
        end else if (step_en && op == ntda_pkg::OP_DIV) begin
            sp_reg <= sp_reg + 1'b1;
        end else if (step_en && op == ntda_pkg::OP_POP) begin
            sp_reg <= sp_reg - 1'b1;
        end
    end

    // character register, loaded by the emitting ops, freed when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en && (op == ntda_pkg::OP_SIGN || op == ntda_pkg::OP_POP
                                 || op == ntda_pkg::OP_POINT || op == ntda_pkg::OP_FRAC)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            case (op)
                ntda_pkg::OP_SIGN: begin
                    m_character_reg <= ntda_pkg::CH_MINUS;
                    m_last_reg      <= 1'b0;
                end
                ntda_pkg::OP_POP: begin
                    m_character_reg <= ntda_pkg::CH_ZERO
                                       + {4'b0000, dig_mem[IDX_W'(sp_reg - 1'b1)]};
                    m_last_reg      <= !status.sp_more && !fix_reg;
                end
                ntda_pkg::OP_POINT: begin
                    m_character_reg <= ntda_pkg::CH_POINT;
                    m_last_reg      <= status.dec_zero;
                end
                ntda_pkg::OP_FRAC: begin
                    m_character_reg <= ntda_pkg::CH_ZERO + {4'b0000, top_digit};
                    m_last_reg      <= !status.dec_more;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

endmodule

>>> src/ntda_useq.sv
// microcode sequencer: step counter, control store and conditional jumps
// depends on ntda_pkg
module ntda_useq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  ntda_pkg::status_t   status,
    output logic                idle,
    output logic                step_en,
    output ntda_pkg::op_t       op
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                     state_reg;
    logic [ntda_pkg::PC_W-1:0]  pc_reg;
    ntda_pkg::ctrl_t            cw;
    logic                       emits;
    logic                       take;

    assign cw    = ntda_pkg::ucode(pc_reg);
    assign emits = cw.op inside {ntda_pkg::OP_SIGN, ntda_pkg::OP_POP,
                                 ntda_pkg::OP_POINT, ntda_pkg::OP_FRAC};

    always_comb begin
        case (cw.cond)
            ntda_pkg::C_NOT_NEG:  take = !status.neg;
            ntda_pkg::C_Q_NZ:     take = status.q_nz;
            ntda_pkg::C_SP_MORE:  take = status.sp_more;
            ntda_pkg::C_NOT_FIX:  take = !status.fix;
            ntda_pkg::C_DEC_ZERO: take = status.dec_zero;
            ntda_pkg::C_DEC_MORE: take = status.dec_more;
            default:              take = 1'b0;
        endcase
    end

    // hold the step while an emitting op waits for the output register
    assign step_en = (state_reg == ST_RUN) && !(emits && status.out_busy);
    assign op      = cw.op;
    assign idle    = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg <= ST_RUN;
                        pc_reg    <= '0;
                    end
                end
                ST_RUN: begin
                    if (step_en) begin
                        if (cw.op == ntda_pkg::OP_DONE) begin
                            state_reg <= ST_IDLE;
                        end else if (take) begin
                            pc_reg <= cw.target;
                        end else begin
                            pc_reg <= pc_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
